@@ design/s2i_pkg.sv @@
// Shared types and constants for the string-to-integer parser.
// No dependencies; imported by every module of the parser.
package s2i_pkg;

  localparam int VALUE_W   = 64;
  localparam int COUNT_W   = 16;
  localparam int OUT_VAL_W = 64;
  localparam int OUT_CNT_W = 16;
  localparam int BASE_W    = 6;
  localparam int DIGIT_W   = 6;
  localparam int PROD_W    = VALUE_W + BASE_W + 1;
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = 1;
  localparam int QCNT_W    = 2;

  localparam logic [BASE_W-1:0]  BASE_RESET = BASE_W'(10);
  localparam logic [BASE_W-1:0]  BASE_MAX   = BASE_W'(36);
  localparam logic [DIGIT_W-1:0] DIGIT_NONE = '1;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7a;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5a;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;

  typedef enum logic [0:0] {
    REG_NUMBER_BASE = 1'b0,
    REG_SIGNED_MODE = 1'b1
  } cfg_reg_e;

  typedef enum logic [6:0] {
    PH_IDLE    = 7'b0000001,
    PH_SPACE   = 7'b0000010,
    PH_SIGNED  = 7'b0000100,
    PH_ZERO    = 7'b0001000,
    PH_HEXMARK = 7'b0010000,
    PH_DIGITS  = 7'b0100000,
    PH_DONE    = 7'b1000000
  } phase_e;

  typedef enum logic [1:0] {
    RK_EMPTY = 2'd0,
    RK_HEX   = 2'd1,
    RK_NUM   = 2'd2
  } res_kind_e;

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic               is_space;
    logic               is_plus;
    logic               is_minus;
    logic               is_x;
    logic               first;
    logic               last;
  } item_t;

  typedef struct packed {
    res_kind_e          kind;
    logic [VALUE_W-1:0] acc;
    logic               neg;
    logic               ovf;
    logic               sig;
    logic [COUNT_W-1:0] cnt;
  } res_t;

endpackage

@@ design/s2i_front.sv @@
// Front end: classifies each incoming character into an item for the queue.
// Depends on s2i_pkg.
module s2i_front (
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    char_byte_i,
  input  logic          first_char_i,
  input  logic          last_char_i,
  output logic          push_o,
  output s2i_pkg::item_t item_o,
  input  logic          q_ready_i
);
  import s2i_pkg::*;

  logic [7:0] c;

  assign c          = char_byte_i;
  assign in_ready_o = q_ready_i;
  assign push_o     = in_valid_i && q_ready_i;

  always_comb begin
    item_o = '0;
    priority if (c >= CH_ZERO && c <= CH_NINE) begin
      item_o.digit = DIGIT_W'(c - CH_ZERO);
    end else if (c >= CH_LA && c <= CH_LZ) begin
      item_o.digit = DIGIT_W'(c - CH_LA + 8'd10);
    end else if (c >= CH_UA && c <= CH_UZ) begin
      item_o.digit = DIGIT_W'(c - CH_UA + 8'd10);
    end else begin
      item_o.digit = DIGIT_NONE;
    end
    item_o.is_space = (c == CH_SP) || (c >= CH_TAB && c <= CH_CR);
    item_o.is_plus  = (c == CH_PLUS);
    item_o.is_minus = (c == CH_MINUS);
    item_o.is_x     = (c == CH_LX) || (c == CH_UX);
    item_o.first    = first_char_i;
    item_o.last     = last_char_i;
  end

endmodule

@@ design/s2i_queue.sv @@
// Two-entry item queue decoupling the classifier from the parse engine.
// Depends on s2i_pkg.
module s2i_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  s2i_pkg::item_t push_item_i,
  output logic           ready_o,
  output logic           valid_o,
  output s2i_pkg::item_t pop_item_o,
  input  logic           pop_i
);
  import s2i_pkg::*;

  item_t             mem_q [QDEPTH];
  logic [QPTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign ready_o    = (cnt_q != QCNT_W'(QDEPTH));
  assign valid_o    = (cnt_q != '0);
  assign pop_item_o = mem_q[rptr_q];
  assign do_push    = push_i && ready_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wptr_d = do_push ? wptr_q + 1'b1 : wptr_q;
    rptr_d = do_pop ? rptr_q + 1'b1 : rptr_q;
    cnt_d  = cnt_q + QCNT_W'(do_push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_item_i;
    end
  end

endmodule

@@ design/s2i_back.sv @@
// Parse engine: per-string state machine, multiply-add accumulator and
// result register. Depends on s2i_pkg.
module s2i_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  input  s2i_pkg::item_t                q_item_i,
  output logic                          q_pop_o,
  input  logic [s2i_pkg::BASE_W-1:0]    number_base_i,
  input  logic                          signed_mode_i,
  output logic                          res_valid_o,
  output s2i_pkg::res_t                 res_o,
  input  logic                          res_ready_i
);
  import s2i_pkg::*;

  phase_e             phase_q, phase_d;
  logic [VALUE_W-1:0] acc_q, acc_d;
  logic               neg_q, neg_d;
  logic               ovf_q, ovf_d;
  logic [BASE_W-1:0]  wb_q, wb_d;
  logic [COUNT_W-1:0] cnt_q, cnt_d;
  logic               res_valid_q, res_valid_d;
  res_t               res_q, res_d;

  logic               slot_free;
  logic [PROD_W-1:0]  sum;

  assign slot_free   = !res_valid_q || res_ready_i;
  assign q_pop_o     = q_valid_i && slot_free;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_comb begin
    logic fin, rej, st, take, bump;
    fin  = 1'b0;
    rej  = 1'b0;
    st   = 1'b0;
    take = 1'b0;
    bump = 1'b0;
    sum  = '0;

    phase_d     = phase_q;
    acc_d       = acc_q;
    neg_d       = neg_q;
    ovf_d       = ovf_q;
    wb_d        = wb_q;
    cnt_d       = cnt_q;
    res_valid_d = res_valid_q && !res_ready_i;
    res_d       = res_q;

    if (q_pop_o) begin
      if (q_item_i.first) begin
        acc_d   = '0;
        neg_d   = 1'b0;
        ovf_d   = 1'b0;
        cnt_d   = '0;
        wb_d    = number_base_i;
        phase_d = PH_SPACE;
        fin     = (number_base_i == BASE_W'(1)) || (number_base_i > BASE_MAX);
      end

      if (!fin && phase_d != PH_IDLE && phase_d != PH_DONE) begin
        unique case (phase_d)
          PH_SPACE: begin
            if (q_item_i.is_space) begin
              bump = 1'b1;
            end else begin
              phase_d = PH_SIGNED;
              if (q_item_i.is_plus || (q_item_i.is_minus && signed_mode_i)) begin
                neg_d = neg_d | q_item_i.is_minus;
                bump  = 1'b1;
              end else begin
                st = 1'b1;
              end
            end
          end
          PH_SIGNED: st = 1'b1;
          PH_ZERO: begin
            if (q_item_i.is_x) begin
              bump    = 1'b1;
              wb_d    = BASE_W'(16);
              phase_d = PH_HEXMARK;
            end else begin
              if (wb_d == '0) wb_d = BASE_W'(8);
              phase_d = PH_DIGITS;
              take    = 1'b1;
            end
          end
          PH_HEXMARK, PH_DIGITS: take = 1'b1;
          default: rej = 1'b1;
        endcase

        if (st) begin
          if (q_item_i.digit == '0 && (wb_d == '0 || wb_d == BASE_W'(16))) begin
            bump    = 1'b1;
            acc_d   = '0;
            phase_d = PH_ZERO;
          end else begin
            if (wb_d == '0) wb_d = BASE_RESET;
            take = 1'b1;
          end
        end

        if (take) begin
          if (wb_d < BASE_W'(2) || q_item_i.digit >= wb_d) begin
            rej = 1'b1;
          end else begin
            sum = PROD_W'(acc_d) * PROD_W'(wb_d) + PROD_W'(q_item_i.digit);
            if (!ovf_d) begin
              if (sum[PROD_W-1:VALUE_W] != '0) begin
                ovf_d = 1'b1;
                acc_d = '1;
              end else begin
                acc_d = sum[VALUE_W-1:0];
              end
            end
            bump    = 1'b1;
            phase_d = PH_DIGITS;
          end
        end

        if (bump && cnt_d != '1) cnt_d = cnt_d + 1'b1;
        fin = rej || q_item_i.last;
      end

      if (fin) begin
        res_valid_d = 1'b1;
        unique case (phase_d)
          PH_HEXMARK:          res_d.kind = RK_HEX;
          PH_ZERO, PH_DIGITS:  res_d.kind = RK_NUM;
          default:             res_d.kind = RK_EMPTY;
        endcase
        res_d.acc = acc_d;
        res_d.neg = neg_d;
        res_d.ovf = ovf_d;
        res_d.sig = signed_mode_i;
        res_d.cnt = cnt_d;
        phase_d   = PH_DONE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      acc_q       <= '0;
      neg_q       <= 1'b0;
      ovf_q       <= 1'b0;
      wb_q        <= BASE_RESET;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      acc_q       <= acc_d;
      neg_q       <= neg_d;
      ovf_q       <= ovf_d;
      wb_q        <= wb_d;
      cnt_q       <= cnt_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

endmodule

@@ design/string_to_integer_parser_core.sv @@
// String-to-integer parser top level: config registers, front/queue/back and
// result saturation. Depends on s2i_pkg, s2i_front, s2i_queue, s2i_back.
// Throughput: one character per cycle while the two-entry queue between
//   classifier and engine has room; it fills only while a result waits.
// Result path: the closing character is written into the queue, popped at the
//   head once the result slot is free, and its result registered in the engine.
// Reset: asynchronous, active low; base 10, signed mode, no string open.
module string_to_integer_parser_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [s2i_pkg::BASE_W-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    char_byte_i,
  input  logic                          first_char_i,
  input  logic                          last_char_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [s2i_pkg::OUT_VAL_W-1:0] parsed_value_o,
  output logic                          out_of_range_o,
  output logic [s2i_pkg::OUT_CNT_W-1:0] chars_consumed_o
);
  import s2i_pkg::*;

  localparam logic [VALUE_W-1:0] VMASK = '1;
  localparam logic [VALUE_W-1:0] SBIT  = VALUE_W'(1) << (VALUE_W - 1);
  localparam logic [VALUE_W-1:0] SMAX  = VMASK >> 1;

  logic [BASE_W-1:0] base_q;
  logic              sig_q;

  logic  push, q_ready, q_valid, q_pop;
  item_t push_item, pop_item;
  res_t  res;

  logic [VALUE_W-1:0]   val;
  logic [OUT_VAL_W-1:0] val_ext;
  logic                 rng;
  logic [COUNT_W-1:0]   cnt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= BASE_RESET;
      sig_q  <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_NUMBER_BASE: base_q <= cfg_wdata_i;
        REG_SIGNED_MODE: sig_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  s2i_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .char_byte_i  (char_byte_i),
    .first_char_i (first_char_i),
    .last_char_i  (last_char_i),
    .push_o       (push),
    .item_o       (push_item),
    .q_ready_i    (q_ready)
  );

  s2i_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .ready_o     (q_ready),
    .valid_o     (q_valid),
    .pop_item_o  (pop_item),
    .pop_i       (q_pop)
  );

  s2i_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_item_i      (pop_item),
    .q_pop_o       (q_pop),
    .number_base_i (base_q),
    .signed_mode_i (sig_q),
    .res_valid_o   (out_valid_o),
    .res_o         (res),
    .res_ready_i   (out_ready_i)
  );

  always_comb begin
    val = '0;
    rng = 1'b0;
    cnt = '0;
    unique case (res.kind)
      RK_HEX: cnt = res.cnt - 1'b1;
      RK_NUM: begin
        cnt = res.cnt;
        if (!res.sig) begin
          val = res.ovf ? VMASK : res.acc;
          rng = res.ovf;
        end else if (res.neg) begin
          if (res.ovf || res.acc > SBIT) begin
            val = SBIT;
            rng = 1'b1;
          end else begin
            val = '0 - res.acc;
          end
        end else begin
          if (res.ovf || res.acc > SMAX) begin
            val = SMAX;
            rng = 1'b1;
          end else begin
            val = res.acc;
          end
        end
      end
      default: ;
    endcase
    val_ext              = {OUT_VAL_W{res.sig && val[VALUE_W-1]}};
    val_ext[VALUE_W-1:0] = val;
  end

  assign parsed_value_o   = val_ext;
  assign out_of_range_o   = rng;
  assign chars_consumed_o = OUT_CNT_W'(cnt);

  a_rng_has_chars : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_of_range_o |-> chars_consumed_o != '0)
    else $error("saturated result with no characters consumed");

  a_empty_is_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && chars_consumed_o == '0 |-> parsed_value_o == '0 && !out_of_range_o)
    else $error("result without characters carries a value");

  a_signed_sat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_of_range_o && res.sig |->
      (parsed_value_o[VALUE_W-2:0] == '1) || (parsed_value_o[VALUE_W-2:0] == '0))
    else $error("signed saturation is not a limit value");

  a_pop_needs_slot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop && out_valid_o |-> out_ready_i)
    else $error("engine advanced while result register was blocked");

endmodule
